// ===== hw/rtl/cfws_pkg.sv =====
// ----------------------------------------------------------------------------
// cfws_pkg
// Shared types, codes and helpers for the circular FIFO with search.
// ----------------------------------------------------------------------------
package cfws_pkg;

   // Storage geometry.
   localparam int unsigned DEPTH  = 16;
   localparam int unsigned ADDR_W = 4;
   localparam int unsigned CNT_W  = 5;
   localparam int unsigned DATA_W = 32;

   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

   // Request operation codes.
   localparam logic [2:0] OP_ENQ    = 3'd0;
   localparam logic [2:0] OP_DEQ    = 3'd1;
   localparam logic [2:0] OP_PEEK   = 3'd2;
   localparam logic [2:0] OP_CLEAR  = 3'd3;
   localparam logic [2:0] OP_SEARCH = 3'd4;

   // Result status codes.
   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_FULL     = 2'd1;
   localparam logic [1:0] STAT_EMPTY    = 2'd2;
   localparam logic [1:0] STAT_NOTFOUND = 2'd3;

   // Request beat.
   typedef struct packed {
      logic [2:0]               req_type;
      logic signed [DATA_W-1:0] value_in;
   } cfws_req_type;

   // Result beat.
   typedef struct packed {
      logic [1:0]               status;
      logic signed [DATA_W-1:0] data_out;
      logic [ADDR_W-1:0]        slot_index;
      logic [CNT_W-1:0]         count;
      logic                     empty_res;
      logic                     full_res;
   } cfws_rsp_type;

   // Controller states.
   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_SCAN,
      S_RESP
   } cfws_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       latch_req;
      logic       enq_write;
      logic       deq_adv;
      logic       clear_ptrs;
      logic       scan_start;
      logic       scan_next;
      logic       load_res;
      logic [1:0] res_code;
      logic       res_use_data;
      logic       res_use_slot;
   } cfws_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [2:0] req_op;
      logic [2:0] hold_op;
      logic       full;
      logic       empty;
      logic       match;
      logic       scan_last;
   } cfws_stat_type;

   // Step a ring pointer, wrapping at the effective capacity.
   function automatic logic [ADDR_W-1:0] ring_adv(input logic [ADDR_W-1:0] p,
                                                  input logic [CNT_W-1:0]  cap);
      logic [CNT_W-1:0] nxt;
      nxt = {1'b0, p} + CNT_W'(1);
      return (nxt >= cap) ? '0 : nxt[ADDR_W-1:0];
   endfunction

   // Clamp a written capacity into 1..DEPTH.
   function automatic logic [CNT_W-1:0] eff_cap(input logic [CNT_W-1:0] v);
      logic [CNT_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = CNT_W'(1);
      end else if (v > DEPTH_CNT) begin
         r = DEPTH_CNT;
      end
      return r;
   endfunction

endpackage

// ===== hw/rtl/circular_fifo_with_search.sv =====
// Enqueue, clear, unknown requests and refused dequeue or peek go straight to a
// result; dequeue and peek first pass through one registered RAM read. Search
// compares the held entries up to and including the first match (all of them
// when there is none, none on an empty queue), one word per cycle.
// One beat at a time: the next request is taken the cycle after a result leaves.
// Synchronous reset empties the queue and sets the capacity to 16.
// ----------------------------------------------------------------------------
// circular_fifo_with_search
// Ring-buffer FIFO of signed words with enqueue, dequeue, peek, clear and
// search, and a programmable capacity.
// ----------------------------------------------------------------------------
module circular_fifo_with_search (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  cfws_pkg::cfws_req_type     req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output cfws_pkg::cfws_rsp_type     rsp_data,
   input  logic                       csr_wr_en,
   input  logic [cfws_pkg::CNT_W-1:0] csr_wr_data
);
   import cfws_pkg::*;

   cfws_cmd_type  cmd;
   cfws_stat_type stat;

   // Sequencing.
   cfws_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Storage, pointers and result.
   cfws_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_data    (rsp_data)
   );

endmodule

// ===== hw/rtl/cfws_ram.sv =====
// ----------------------------------------------------------------------------
// cfws_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module cfws_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, registered every cycle.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/cfws_datapath.sv =====
// ----------------------------------------------------------------------------
// cfws_datapath
// Pointers, count, capacity, slot storage, search scan and result register.
// ----------------------------------------------------------------------------
module cfws_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  cfws_pkg::cfws_req_type       req_data,
   input  logic                         csr_wr_en,
   input  logic [cfws_pkg::CNT_W-1:0]   csr_wr_data,
   input  cfws_pkg::cfws_cmd_type       cmd,
   output cfws_pkg::cfws_stat_type      stat,
   output cfws_pkg::cfws_rsp_type       rsp_data
);
   import cfws_pkg::*;

   logic [CNT_W-1:0]  cap_ff, cap_in;
   logic [ADDR_W-1:0] head_ff, head_in;
   logic [ADDR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0]  held_ff, held_in;

   logic [2:0]        op_ff;
   logic [DATA_W-1:0] key_ff;
   logic [ADDR_W-1:0] scan_ff, scan_in;
   logic [CNT_W-1:0]  left_ff, left_in;

   logic [1:0]        res_status_ff;
   logic [DATA_W-1:0] res_data_ff;
   logic [ADDR_W-1:0] res_slot_ff;

   logic [ADDR_W-1:0] rd_addr;
   logic [DATA_W-1:0] rd_data;

   // Slot storage.
   cfws_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.enq_write),
      .wr_addr (tail_ff),
      .wr_data (req_data.value_in),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // The read address follows the scan while it steps, otherwise the head.
   assign rd_addr = cmd.scan_next ? ring_adv(scan_ff, cap_ff) : head_ff;

   // Next values for capacity, pointers and count.
   always_comb begin
      cap_in  = cap_ff;
      head_in = head_ff;
      tail_in = tail_ff;
      held_in = held_ff;
      priority if (csr_wr_en) begin
         cap_in  = eff_cap(csr_wr_data);
         head_in = '0;
         tail_in = '0;
         held_in = '0;
      end else if (cmd.clear_ptrs) begin
         head_in = '0;
         tail_in = '0;
         held_in = '0;
      end else if (cmd.enq_write) begin
         tail_in = ring_adv(tail_ff, cap_ff);
         held_in = held_ff + CNT_W'(1);
      end else if (cmd.deq_adv) begin
         head_in = ring_adv(head_ff, cap_ff);
         held_in = held_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff  <= DEPTH_CNT;
         head_ff <= '0;
         tail_ff <= '0;
         held_ff <= '0;
      end else begin
         cap_ff  <= cap_in;
         head_ff <= head_in;
         tail_ff <= tail_in;
         held_ff <= held_in;
      end
   end

   // Scan pointer and remaining entry count.
   always_comb begin
      scan_in = scan_ff;
      left_in = left_ff;
      priority if (cmd.scan_start) begin
         scan_in = head_ff;
         left_in = held_ff;
      end else if (cmd.scan_next) begin
         scan_in = ring_adv(scan_ff, cap_ff);
         left_in = left_ff - CNT_W'(1);
      end
   end

   // Request capture, scan state and result payload.
   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         op_ff  <= req_data.req_type;
         key_ff <= req_data.value_in;
      end
      scan_ff <= scan_in;
      left_ff <= left_in;
      if (cmd.load_res) begin
         res_status_ff <= cmd.res_code;
         res_data_ff   <= cmd.res_use_data ? rd_data : '0;
         res_slot_ff   <= cmd.res_use_slot ? scan_ff : '0;
      end
   end

   // Status toward the controller.
   assign stat.req_op    = req_data.req_type;
   assign stat.hold_op   = op_ff;
   assign stat.full      = (held_ff >= cap_ff);
   assign stat.empty     = (held_ff == '0);
   assign stat.match     = (rd_data == key_ff);
   assign stat.scan_last = (left_ff == CNT_W'(1));

   // Result beat; count and flags are stable while a result waits, unless the capacity is written.
   assign rsp_data.status     = res_status_ff;
   assign rsp_data.data_out   = res_data_ff;
   assign rsp_data.slot_index = res_slot_ff;
   assign rsp_data.count      = held_ff;
   assign rsp_data.empty_res  = (held_ff == '0);
   assign rsp_data.full_res   = (held_ff == cap_ff);

endmodule

// ===== hw/rtl/cfws_ctrl.sv =====
// ----------------------------------------------------------------------------
// cfws_ctrl
// Controller state machine sequencing requests, reads, scans and results.
// ----------------------------------------------------------------------------
module cfws_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  cfws_pkg::cfws_stat_type stat,
   output cfws_pkg::cfws_cmd_type  cmd
);
   import cfws_pkg::*;

   cfws_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               unique case (stat.req_op)
                  OP_DEQ, OP_PEEK: begin
                     state_in = stat.empty ? S_RESP : S_READ;
                  end
                  OP_SEARCH: begin
                     state_in = stat.empty ? S_RESP : S_SCAN;
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end
         end
         S_READ: begin
            state_in = S_RESP;
         end
         S_SCAN: begin
            if (stat.match || stat.scan_last) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Handshake and datapath commands.
   always_comb begin
      cmd       = '0;
      req_stall = (state_ff != S_IDLE);
      rsp_valid = (state_ff == S_RESP);
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               cmd.load_res  = 1'b1;
               cmd.res_code  = STAT_OK;
               unique case (stat.req_op)
                  OP_ENQ: begin
                     if (stat.full) begin
                        cmd.res_code = STAT_FULL;
                     end else begin
                        cmd.enq_write = 1'b1;
                     end
                  end
                  OP_DEQ, OP_PEEK: begin
                     if (stat.empty) begin
                        cmd.res_code = STAT_EMPTY;
                     end else begin
                        cmd.load_res = 1'b0;
                     end
                  end
                  OP_CLEAR: begin
                     cmd.clear_ptrs = 1'b1;
                  end
                  OP_SEARCH: begin
                     if (stat.empty) begin
                        cmd.res_code = STAT_NOTFOUND;
                     end else begin
                        cmd.load_res   = 1'b0;
                        cmd.scan_start = 1'b1;
                     end
                  end
                  default: begin
                     cmd.res_code = STAT_OK;
                  end
               endcase
            end
         end
         S_READ: begin
            // The head word is on the read port now.
            cmd.load_res     = 1'b1;
            cmd.res_code     = STAT_OK;
            cmd.res_use_data = 1'b1;
            cmd.deq_adv      = (stat.hold_op == OP_DEQ);
         end
         S_SCAN: begin
            if (stat.match) begin
               cmd.load_res     = 1'b1;
               cmd.res_code     = STAT_OK;
               cmd.res_use_slot = 1'b1;
            end else if (stat.scan_last) begin
               cmd.load_res = 1'b1;
               cmd.res_code = STAT_NOTFOUND;
            end else begin
               cmd.scan_next = 1'b1;
            end
         end
         S_RESP: begin
            cmd = '0;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule
